/* design/ngvf_pkg.sv */
// Shared types and constants for the NGARCH variance filter.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package ngvf_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned HIST_DEPTH = 3;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned ROOT_W     = 24;
  localparam int unsigned ITER_W     = $clog2(ROOT_W + 1);
  localparam int unsigned SUM_W      = 52;
  localparam int unsigned CELL_LAT   = 8;
  localparam int unsigned SQ_W       = 49;

  localparam logic [SQ_W-1:0] SQ_CAP   = SQ_W'(1) << 48;
  localparam logic [DATA_W:0] TERM_CAP = (DATA_W + 1)'(1) << DATA_W;

  typedef enum logic [2:0] {
    REG_VAR_CONST,
    REG_THETA,
    REG_ARCH_1,
    REG_ARCH_2,
    REG_ARCH_3,
    REG_GARCH_1,
    REG_GARCH_2,
    REG_GARCH_3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_SETTLE,
    ST_DONE
  } state_e;

  // one lag: residual, variance and root variance
  typedef struct packed {
    logic signed [DATA_W-1:0] u;
    logic [DATA_W-1:0]        h;
    logic [ROOT_W-1:0]        r;
  } lag_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_st_t;

endpackage

/* design/ngvf_if.sv */
// Valid/ready channel interfaces for the residual input and variance output.
// Depends on ngvf_pkg.
`timescale 1ns / 1ps

interface ngvf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ngvf_pkg::DATA_W-1:0]  residual;

  modport source (output valid, output residual, input ready);
  modport sink   (input valid, input residual, output ready);
endinterface

interface ngvf_out_if;
  logic                         valid;
  logic                         ready;
  logic [ngvf_pkg::DATA_W-1:0]  next_variance;
  logic                         overflow;

  modport source (output valid, output next_variance, output overflow, input ready);
  modport sink   (input valid, input next_variance, input overflow, output ready);
endinterface

/* design/ngarch_variance_filter_top.sv */
// NGARCH conditional variance filter, top level.
// Depends on ngvf_pkg, ngvf_if, ngvf_sqrt, ngvf_cell.
//
// Usage:
//  - in_i carries one signed Q16.16 residual per transfer; out_o returns one
//    unsigned Q16.16 next variance per transfer, with overflow set when the
//    value saturated at all ones.
//  - Coefficients are written over the APB port (register i at byte 4*i); the user must
//    write them only while no item is in flight, which the block itself leaves unchecked.
//  - One item is processed at a time. A transfer starts a bit-serial square root
//    of the current variance, the root and residual shift into the row of lag
//    cells, and the result is loaded into the output register once the cell row
//    has settled. The square root and the settling of the cell row set the rate:
//    the next residual can transfer in the cycle after the result is loaded.
//  - The result sits in an output register; the next residual is taken once the
//    result is loaded, even while the receiver stalls. A further result waits
//    in the block until the output register is free.
//  - Reset clears the configuration and control registers, the lag histories and
//    the output valid; the first item uses var_constant as its variance.
`timescale 1ns / 1ps

module ngarch_variance_filter_top #(
  parameter int unsigned ARCH_LAGS  = 3,
  parameter int unsigned GARCH_LAGS = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ngvf_in_if.sink                       in_i,
  ngvf_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ngvf_pkg::ADDR_W-1:0]   paddr,
  input  logic [ngvf_pkg::DATA_W-1:0]   pwdata,
  output logic [ngvf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import ngvf_pkg::*;

  localparam int unsigned NCELL  = (ARCH_LAGS > GARCH_LAGS) ? ARCH_LAGS : GARCH_LAGS;
  localparam int unsigned SETTLE = CELL_LAT + NCELL;
  localparam int unsigned CNT_W  = $clog2(SETTLE + 1);

  // configuration registers
  logic [DATA_W-1:0]        var_const_q;
  logic signed [DATA_W-1:0] theta_q;
  logic [DATA_W-1:0]        arch_q  [HIST_DEPTH];
  logic [DATA_W-1:0]        garch_q [HIST_DEPTH];
  reg_idx_e                 reg_idx;
  logic                     cfg_wr;

  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_const_q <= '0;
      theta_q     <= '0;
      for (int k = 0; k < HIST_DEPTH; k++) begin
        arch_q[k]  <= '0;
        garch_q[k] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_VAR_CONST: var_const_q <= pwdata;
        REG_THETA:     theta_q     <= pwdata;
        REG_ARCH_1:    arch_q[0]   <= pwdata;
        REG_ARCH_2:    arch_q[1]   <= pwdata;
        REG_ARCH_3:    arch_q[2]   <= pwdata;
        REG_GARCH_1:   garch_q[0]  <= pwdata;
        REG_GARCH_2:   garch_q[1]  <= pwdata;
        REG_GARCH_3:   garch_q[2]  <= pwdata;
        default:       var_const_q <= var_const_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_VAR_CONST: prdata = var_const_q;
      REG_THETA:     prdata = theta_q;
      REG_ARCH_1:    prdata = arch_q[0];
      REG_ARCH_2:    prdata = arch_q[1];
      REG_ARCH_3:    prdata = arch_q[2];
      REG_GARCH_1:   prdata = garch_q[0];
      REG_GARCH_2:   prdata = garch_q[1];
      REG_GARCH_3:   prdata = garch_q[2];
      default:       prdata = '0;
    endcase
  end

  // control
  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [DATA_W-1:0] u_q;
  logic [DATA_W-1:0]        h_q, h_d;
  logic [DATA_W-1:0]        cur_q;
  logic                     primed_q;
  logic                     out_valid_q;
  logic [DATA_W-1:0]        out_var_q;
  logic                     out_ovf_q;

  logic                     in_ready;
  logic                     accept;
  logic                     sqrt_start;
  logic                     shift;
  logic                     load_out;

  sqrt_st_t                 sqrt_st;
  logic [ROOT_W-1:0]        root;

  lag_t                     lag_chain [NCELL+1];
  logic [SUM_W-1:0]         sum_chain [NCELL+1];
  logic [SUM_W-1:0]         sum_last;
  logic                     res_ovf;
  logic [DATA_W-1:0]        res_var;

  assign accept = in_i.valid && in_ready;
  assign h_d    = primed_q ? cur_q : var_const_q;

  always_comb begin
    state_d    = state_q;
    in_ready   = 1'b0;
    sqrt_start = 1'b0;
    shift      = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready   = 1'b1;
        sqrt_start = in_i.valid;
        if (in_i.valid) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sqrt_st.done) begin
          shift   = 1'b1;
          state_d = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cur_q       <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (shift) begin
        cnt_q <= CNT_W'(SETTLE);
      end else if (state_q == ST_SETTLE) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (load_out) begin
        cur_q       <= res_var;
        primed_q    <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      u_q <= in_i.residual;
      h_q <= h_d;
    end
    if (load_out) begin
      out_var_q <= res_var;
      out_ovf_q <= res_ovf;
    end
  end

  ngvf_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (h_d),
    .st_o       (sqrt_st),
    .root_o     (root)
  );

  // row of lag cells, newest lag first
  assign lag_chain[0].u = u_q;
  assign lag_chain[0].h = h_q;
  assign lag_chain[0].r = root;
  assign sum_chain[0]   = SUM_W'(var_const_q);

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    ngvf_cell #(
      .USE_ARCH  (k < ARCH_LAGS),
      .USE_GARCH (k < GARCH_LAGS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_i      (shift),
      .lag_i        (lag_chain[k]),
      .lag_o        (lag_chain[k+1]),
      .theta_i      (theta_q),
      .arch_coef_i  (arch_q[k]),
      .garch_coef_i (garch_q[k]),
      .sum_i        (sum_chain[k]),
      .sum_o        (sum_chain[k+1])
    );
  end

  assign sum_last = sum_chain[NCELL];
  assign res_ovf  = |sum_last[SUM_W-1:DATA_W];
  assign res_var  = res_ovf ? '1 : sum_last[DATA_W-1:0];

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.next_variance = out_var_q;
  assign out_o.overflow      = out_ovf_q;

endmodule

/* design/ngvf_sqrt.sv */
// Bit-serial integer square root of h * 2^16, one root bit per cycle.
// Depends on ngvf_pkg.
`timescale 1ns / 1ps

module ngvf_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ngvf_pkg::DATA_W-1:0]   radicand_i,
  output ngvf_pkg::sqrt_st_t            st_o,
  output logic [ngvf_pkg::ROOT_W-1:0]   root_o
);
  import ngvf_pkg::*;

  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [ITER_W-1:0] cnt_q;
  logic              busy_q, done_q;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              fits;

  always_comb begin
    rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= ITER_W'(ROOT_W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != ITER_W'(1));
      done_q <= (cnt_q == ITER_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {radicand_i, {(RAD_W - DATA_W){1'b0}}};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign root_o    = root_q;

endmodule

/* design/ngvf_cell.sv */
// One lag cell: holds one history entry, passes it to the next cell on a shift,
// computes its ARCH and GARCH terms and adds each enabled term to the running sum.
// Depends on ngvf_pkg.
`timescale 1ns / 1ps

module ngvf_cell #(
  parameter bit USE_ARCH  = 1'b1,
  parameter bit USE_GARCH = 1'b1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                shift_i,
  input  ngvf_pkg::lag_t                      lag_i,
  output ngvf_pkg::lag_t                      lag_o,
  input  logic signed [ngvf_pkg::DATA_W-1:0]  theta_i,
  input  logic [ngvf_pkg::DATA_W-1:0]         arch_coef_i,
  input  logic [ngvf_pkg::DATA_W-1:0]         garch_coef_i,
  input  logic [ngvf_pkg::SUM_W-1:0]          sum_i,
  output logic [ngvf_pkg::SUM_W-1:0]          sum_o
);
  import ngvf_pkg::*;

  localparam int unsigned PROD_W = DATA_W + ROOT_W + 1;
  localparam int unsigned T_W    = PROD_W - FRAC_W;
  localparam int unsigned D_W    = T_W + 1;
  localparam int unsigned GH_W   = 2 * DATA_W;
  localparam int unsigned HP_W   = 2 * DATA_W + 1;
  localparam int unsigned LP_W   = DATA_W + FRAC_W;

  lag_t                     lag_q;
  logic signed [PROD_W-1:0] p_q;
  logic [GH_W-1:0]          gh_q;
  logic signed [T_W-1:0]    t_q;
  logic signed [D_W-1:0]    d_q;
  logic [DATA_W-1:0]        m_lo_q;
  logic                     big_q;
  logic [SQ_W-1:0]          sq_q;
  logic [HP_W-1:0]          hp_q;
  logic [LP_W-1:0]          lp_q;
  logic [DATA_W:0]          at_q;
  logic [SUM_W-1:0]         sum_q;

  logic signed [PROD_W-1:0] p_bias;
  logic [D_W-1:0]           m_abs;
  logic [GH_W-1:0]          m_sq;
  logic [DATA_W:0]          at_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q <= '0;
    end else if (shift_i) begin
      lag_q <= lag_i;
    end
  end

  always_comb begin
    // truncate toward zero: bias negative products before the shift
    p_bias = p_q + (p_q[PROD_W-1] ? PROD_W'((1 << FRAC_W) - 1) : PROD_W'(0));
    m_abs  = d_q[D_W-1] ? D_W'(-d_q) : D_W'(d_q);
    m_sq   = GH_W'(m_lo_q) * GH_W'(m_lo_q);
    at_sum = {1'b0, hp_q[DATA_W-1:0]} + {1'b0, lp_q[LP_W-1:FRAC_W]};
  end

  // free-running pipeline (p, t, d, m, sq, hp/lp, at, sum); settles after the history changes
  always_ff @(posedge clk_i) begin
    p_q    <= theta_i * $signed({1'b0, lag_q.r});
    gh_q   <= GH_W'(garch_coef_i) * GH_W'(lag_q.h);
    t_q    <= p_bias[PROD_W-1:FRAC_W];
    d_q    <= {{(D_W - DATA_W){lag_q.u[DATA_W-1]}}, lag_q.u} - {t_q[T_W-1], t_q};
    m_lo_q <= m_abs[DATA_W-1:0];
    big_q  <= |m_abs[D_W-1:DATA_W];
    sq_q   <= big_q ? SQ_CAP : {1'b0, m_sq[GH_W-1:FRAC_W]};
    hp_q   <= HP_W'(arch_coef_i) * HP_W'(sq_q[SQ_W-1:FRAC_W]);
    lp_q   <= LP_W'(arch_coef_i) * LP_W'(sq_q[FRAC_W-1:0]);
    if (|hp_q[HP_W-1:DATA_W]) begin
      at_q <= TERM_CAP;
    end else begin
      at_q <= (at_sum > TERM_CAP) ? TERM_CAP : at_sum;
    end
    sum_q  <= sum_i
            + (USE_ARCH  ? SUM_W'(at_q) : SUM_W'(0))
            + (USE_GARCH ? SUM_W'(gh_q[GH_W-1:FRAC_W]) : SUM_W'(0));
  end

  assign lag_o = lag_q;
  assign sum_o = sum_q;

endmodule

/* design/ngvf_checker.sv */
// Port-level checks for the NGARCH variance filter, bound to the top level.
// Depends on ngvf_pkg and ngarch_variance_filter_top.
`timescale 1ns / 1ps

module ngvf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [ngvf_pkg::DATA_W-1:0]  next_variance_i,
  input logic                         overflow_i
);
  import ngvf_pkg::*;

  // a saturated result is all ones
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && overflow_i |-> next_variance_i == {DATA_W{1'b1}})
    else $error("overflow set without saturated variance");

  // one item at a time: input closes right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while an item is in flight");

  // no result can follow an input transfer in the next cycle
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared too early");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(next_variance_i)
      && $stable(overflow_i))
    else $error("stalled result changed");

endmodule

bind ngarch_variance_filter_top ngvf_checker u_ngvf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .next_variance_i (out_o.next_variance),
  .overflow_i      (out_o.overflow)
);

/* test/tb_ngarch_variance_filter_top.sv */
// Self-checking testbench for ngarch_variance_filter_top: a directed residual sequence and random
// residual streams under several coefficient settings, checked against a bit-exact variance predictor.
// Depends on ngvf_pkg, ngvf_if and the design sources.
`timescale 1ns / 1ps

module tb_ngarch_variance_filter_top;
  import ngvf_pkg::*;

  localparam int unsigned ARCH_LAGS  = 3;
  localparam int unsigned GARCH_LAGS = 3;
  localparam int unsigned SETTLE     = 45;
  localparam int unsigned PHASES     = 12;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam logic [63:0] TERM_LIMIT = 64'd1 << 32;
  localparam logic [63:0] SQ_LIMIT   = 64'd1 << 48;

  typedef struct packed {
    logic [31:0] variance;
    logic        overflow;
  } variance_result_t;

  class variance_scoreboard;
    logic [31:0] var_const;
    logic [31:0] theta;
    logic [31:0] arch_w [3];
    logic [31:0] garch_w [3];
    logic [31:0] u_lag [3];
    logic [31:0] h_lag [3];
    logic [23:0] root_lag [3];
    logic [31:0] last_variance;
    bit          primed;
    variance_result_t expected_q [$];
    int unsigned mismatches;
    int unsigned residuals_seen;
    int unsigned saturated;

    function new();
      var_const = '0;
      theta = '0;
      last_variance = '0;
      primed = 1'b0;
      mismatches = 0;
      residuals_seen = 0;
      saturated = 0;
      for (int k = 0; k < 3; k++) begin
        arch_w[k] = '0;
        garch_w[k] = '0;
        u_lag[k] = '0;
        h_lag[k] = '0;
        root_lag[k] = '0;
      end
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] val);
      case (idx)
        REG_VAR_CONST: var_const = val;
        REG_THETA:     theta = val;
        REG_ARCH_1:    arch_w[0] = val;
        REG_ARCH_2:    arch_w[1] = val;
        REG_ARCH_3:    arch_w[2] = val;
        REG_GARCH_1:   garch_w[0] = val;
        REG_GARCH_2:   garch_w[1] = val;
        REG_GARCH_3:   garch_w[2] = val;
        default: ;
      endcase
    endfunction

    // floor(sqrt(x)) by trial bits, x = h << 16
    function logic [23:0] root_of(logic [47:0] x);
      logic [23:0] r;
      logic [47:0] trial;
      r = '0;
      for (int b = 23; b >= 0; b--) begin
        trial = {24'd0, r | (24'd1 << b)};
        if (trial * trial <= x) r = r | (24'd1 << b);
      end
      return r;
    endfunction

    function logic [63:0] arch_term(logic [31:0] w, logic [31:0] u, logic [23:0] r);
      logic signed [63:0] p;
      logic signed [63:0] t;
      logic signed [63:0] d;
      logic [63:0] mag;
      logic [63:0] m;
      logic [63:0] sq;
      logic [95:0] prod;
      p = $signed({{32{theta[31]}}, theta} * {40'd0, r});
      mag = (p < 0) ? 64'(-p) : 64'(p);
      t = $signed(mag >> 16);
      if (p < 0) t = -t;
      d = $signed({{32{u[31]}}, u}) - t;
      m = (d < 0) ? 64'(-d) : 64'(d);
      if (m >= 64'd1 << 32) begin
        sq = SQ_LIMIT;
      end else begin
        sq = (m * m) >> 16;
        if (sq > SQ_LIMIT) sq = SQ_LIMIT;
      end
      prod = ({64'd0, w} * {32'd0, sq}) >> 16;
      return (prod > {32'd0, TERM_LIMIT}) ? TERM_LIMIT : prod[63:0];
    endfunction

    function void note_residual(logic [31:0] u);
      logic [31:0] h;
      logic [63:0] acc;
      variance_result_t res;
      h = primed ? last_variance : var_const;
      for (int k = 2; k > 0; k--) begin
        u_lag[k] = u_lag[k-1];
        h_lag[k] = h_lag[k-1];
        root_lag[k] = root_lag[k-1];
      end
      u_lag[0] = u;
      h_lag[0] = h;
      root_lag[0] = root_of({h, 16'd0});
      acc = {32'd0, var_const};
      for (int k = 0; k < ARCH_LAGS; k++) acc += arch_term(arch_w[k], u_lag[k], root_lag[k]);
      for (int k = 0; k < GARCH_LAGS; k++) acc += ({32'd0, garch_w[k]} * {32'd0, h_lag[k]}) >> 16;
      res.overflow = (acc > 64'hFFFF_FFFF);
      res.variance = res.overflow ? 32'hFFFF_FFFF : acc[31:0];
      last_variance = res.variance;
      primed = 1'b1;
      residuals_seen++;
      expected_q.push_back(res);
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (mismatches < 10)
        $display("%0t: %s mismatch: expected %h, got %h", $time, field, exp_v, act_v);
      mismatches++;
    endfunction

    function void check_result(logic [31:0] variance, logic overflow);
      variance_result_t exp_r;
      if (expected_q.size() == 0) begin
        report("unexpected result, variance", 32'hx, variance);
        return;
      end
      exp_r = expected_q.pop_front();
      if (exp_r.overflow) saturated++;
      if (variance !== exp_r.variance) report("next_variance", exp_r.variance, variance);
      if (overflow !== exp_r.overflow) report("overflow", 32'(exp_r.overflow), 32'(overflow));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  bit          steady;
  int unsigned settings_applied;

  ngvf_in_if  in_bus ();
  ngvf_out_if out_bus ();

  variance_scoreboard sb = new();

  ngarch_variance_filter_top #(
    .ARCH_LAGS (ARCH_LAGS),
    .GARCH_LAGS(GARCH_LAGS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // block must be idle: wait out all results plus the tail of the pipeline
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [31:0] vals [8]);
    drain();
    for (int i = 0; i < 8; i++) write_reg(reg_idx_e'(i), vals[i]);
    settings_applied++;
  endtask

  task automatic send_residual(logic [31:0] u);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.residual <= u;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_residual(u);
  endtask

  function automatic logic [31:0] pick_residual();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom;
      2: v = 32'h0;
      3: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: v = 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endcase
    return v;
  endfunction

  // coefficient sets that keep the recursion mostly out of saturation
  task automatic pick_settings(int unsigned phase, output logic [31:0] vals [8]);
    vals[REG_VAR_CONST] = $urandom_range(0, 32'h0004_0000);
    vals[REG_THETA]     = 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
    for (int k = 0; k < 3; k++) begin
      vals[REG_ARCH_1 + k]  = $urandom_range(0, 32'h0000_8000);
      vals[REG_GARCH_1 + k] = $urandom_range(0, 32'h0000_5000);
    end
    case (phase)
      0: for (int i = 0; i < 8; i++) vals[i] = 32'h0;
      1: for (int i = 0; i < 8; i++) vals[i] = 32'hFFFF_FFFF;
      2: vals[REG_THETA] = 32'h8000_0000;
      3: vals[REG_THETA] = 32'h7FFF_FFFF;
      4: begin
        vals[REG_VAR_CONST] = 32'hFFFF_FFFF;
        for (int k = 0; k < 3; k++) vals[REG_GARCH_1 + k] = 32'h0;
      end
      7: vals[$urandom_range(0, 7)] = $urandom;
      default: ;
    endcase
  endtask

  initial begin
    logic [31:0] cfg [8];
    logic [31:0] directed [20];
    directed = '{32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001,
                 32'hFFFF_FFFF, 32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 32'h0001_8000,
                 32'hFFFF_8000, 32'h0000_FFFF, 32'h0003_0000, 32'h0000_0000};
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_bus.valid <= 1'b0;
    in_bus.residual <= '0;
    steady = 1'b0;
    settings_applied = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // moderate model: const 1.0, theta 0.5, arch .1/.05/.02, garch .6/.1/.05
    cfg = '{32'h0001_0000, 32'h0000_8000, 32'h0000_199A, 32'h0000_0CCD,
            32'h0000_051F, 32'h0000_999A, 32'h0000_199A, 32'h0000_0CCD};
    load_settings(cfg);
    foreach (directed[i]) send_residual(directed[i]);

    for (int p = 0; p < PHASES; p++) begin
      pick_settings(p, cfg);
      load_settings(cfg);
      steady = (p == 5 || p == 9);
      for (int n = 0; n < PHASE_ITEMS; n++) send_residual(pick_residual());
      steady = 1'b0;
    end

    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("%0d residuals checked across %0d coefficient sets, %0d saturated results",
             sb.residuals_seen, settings_applied, sb.saturated);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("end of test: mismatches");
    end
    $finish;
  end

  // result side: random stalls, with idle-free stretches in steady phases
  initial begin
    int unsigned stall;
    out_bus.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
      sb.check_result(out_bus.next_variance, out_bus.overflow);
    end
  end

endmodule
